@@ sv/pip_pkg.sv @@
package pip_pkg;

  // Widths of the transaction fields
  localparam int unsigned CmdW    = 2;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned StatusW = 2;

  // Defaults for the top-level parameters
  localparam int unsigned DefMaxVertices = 64;
  localparam int unsigned DefCoordBits   = 16;

  // Smallest polygon that can enclose anything
  localparam int unsigned MinPoly = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2
  } status_e;

endpackage

@@ sv/point_in_polygon_test.sv @@
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ---------------------------------
// in        sink       in_valid_i/in_ready_o  cmd_i, px_i, py_i
// out       source     out_valid_o/out_ready_i inside_res_o, on_edge_o, status_o
//
// Clear, append, unknown commands and queries on fewer than three vertices
// have their result loaded into the output register at accept. A query
// on n vertices walks the stored polygon through the single read port of the
// vertex memory, one vertex a cycle, a rate that the read port sets.
// rst_ni clears the vertex count and all control; the vertex memory has no reset.
// A result waits in the output register; no new transaction is taken until it
// leaves, at the earliest in the same cycle it is taken.
module point_in_polygon_test #(
  parameter int unsigned MAX_VERTICES = pip_pkg::DefMaxVertices,
  parameter int unsigned COORD_BITS   = pip_pkg::DefCoordBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pip_pkg::CmdW-1:0]            cmd_i,
  input  logic signed [pip_pkg::FieldW-1:0]   px_i,
  input  logic signed [pip_pkg::FieldW-1:0]   py_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                inside_res_o,
  output logic                                on_edge_o,
  output logic [pip_pkg::StatusW-1:0]         status_o
);
  import pip_pkg::*;

  // Stored coordinate width: the field wrapped to COORD_BITS, never wider than the field
  localparam int unsigned CW   = (COORD_BITS < FieldW) ? COORD_BITS : FieldW;
  localparam int unsigned DW   = CW + 1;        // difference of two coordinates
  localparam int unsigned PW   = 2 * DW;        // product of two differences
  localparam int unsigned AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;  // issue one vertex read a cycle
  localparam logic [2:0] S_WRAP = 3'd2;  // close the polygon with the first vertex
  localparam logic [2:0] S_WAIT = 3'd3;  // drain the edge pipeline
  localparam logic [2:0] S_DONE = 3'd4;  // hand the verdict to the output register

  logic [2:0] state_q, state_d;

  // Vertex memory, one synchronous read port
  logic [CW-1:0] x_mem [MAX_VERTICES];
  logic [CW-1:0] y_mem [MAX_VERTICES];
  logic signed [CW-1:0] rd_x_q, rd_y_q;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CNTW-1:0] n_q;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;

  logic signed [CW-1:0] qx_q, qy_q;
  logic signed [CW-1:0] in_x, in_y;

  logic in_fire, wr_en, rd_en, out_free;
  logic last_rd;

  // Read stage flags
  logic rd_vld_q, rd_vld_d, rd_first_q, rd_first_d, rd_wrap_q, rd_wrap_d;

  logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CW-1:0] cur_x, cur_y;

  // Edge stage
  logic signed [DW-1:0] dx_ba, dy_ba, px_a, py_a, px_b, py_b, dx_ab, dy_ab;
  logic signed [PW-1:0] cr_a, cr_b, lhs, rhs;
  logic signed [PW-1:0] cr_a_q, cr_b_q, lhs_q, rhs_q;
  logic box_ok, straddle, dpos;
  logic box_q, straddle_q, dpos_q;
  logic ex_vld_q, ex_vld_d, ex_last_q;

  logic on_hit, cross_hit;
  logic edge_acc_q, par_acc_q;

  logic out_valid_q, inside_q, on_edge_q;
  logic [StatusW-1:0] status_q;
  logic out_load;
  logic out_inside, out_edge;
  logic [StatusW-1:0] out_status;

  assign in_x = CW'(px_i);
  assign in_y = CW'(py_i);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign wr_en   = in_fire && (cmd_i == CMD_APPEND) && (cnt_q < CNTW'(MAX_VERTICES));
  assign rd_en   = (state_q == S_RUN);
  assign last_rd = (CNTW'(rd_ptr_q) == n_q - CNTW'(1));

  // Control
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_ptr_d   = rd_ptr_q;
    rd_vld_d   = 1'b0;
    rd_first_d = 1'b0;
    rd_wrap_d  = 1'b0;
    out_load   = 1'b0;
    out_inside = 1'b0;
    out_edge   = 1'b0;
    out_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            CMD_CLEAR: begin
              cnt_d    = '0;
              out_load = 1'b1;
            end
            CMD_APPEND: begin
              out_load = 1'b1;
              if (wr_en) begin
                cnt_d = cnt_q + CNTW'(1);
              end else begin
                out_status = ST_FULL;
              end
            end
            CMD_QUERY: begin
              if (cnt_q < CNTW'(MinPoly)) begin
                out_load   = 1'b1;
                out_status = ST_SHORT;
              end else begin
                rd_ptr_d = '0;
                state_d  = S_RUN;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        rd_vld_d   = 1'b1;
        rd_first_d = (rd_ptr_q == '0);
        if (last_rd) begin
          state_d = S_WRAP;
        end else begin
          rd_ptr_d = rd_ptr_q + AW'(1);
        end
      end
      S_WRAP: begin
        rd_vld_d  = 1'b1;
        rd_wrap_d = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (ex_vld_q && ex_last_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_inside = edge_acc_q || par_acc_q;
          out_edge   = edge_acc_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      rd_ptr_q   <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      rd_wrap_q  <= 1'b0;
      ex_vld_q   <= 1'b0;
      ex_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_ptr_q   <= rd_ptr_d;
      rd_vld_q   <= rd_vld_d;
      rd_first_q <= rd_first_d;
      rd_wrap_q  <= rd_wrap_d;
      ex_vld_q   <= ex_vld_d;
      ex_last_q  <= rd_vld_q && rd_wrap_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Vertex memory: written by appends, read during a query walk only
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_mem[cnt_q[AW-1:0]] <= in_x;
      y_mem[cnt_q[AW-1:0]] <= in_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_x_q <= x_mem[rd_ptr_q];
      rd_y_q <= y_mem[rd_ptr_q];
    end
  end

  // Query point and walk length, taken at accept
  always_ff @(posedge clk_i) begin
    if (in_fire && (cmd_i == CMD_QUERY)) begin
      qx_q <= in_x;
      qy_q <= in_y;
      n_q  <= cnt_q;
    end
  end

  // Edge stage 1: prev -> cur is the edge (j -> i); the wrap step closes with vertex 0
  assign cur_x = rd_wrap_q ? first_x_q : rd_x_q;
  assign cur_y = rd_wrap_q ? first_y_q : rd_y_q;

  assign dx_ba = DW'(cur_x) - DW'(prev_x_q);
  assign dy_ba = DW'(cur_y) - DW'(prev_y_q);
  assign px_a  = DW'(qx_q)  - DW'(prev_x_q);
  assign py_a  = DW'(qy_q)  - DW'(prev_y_q);
  assign px_b  = DW'(qx_q)  - DW'(cur_x);
  assign py_b  = DW'(qy_q)  - DW'(cur_y);
  assign dx_ab = DW'(prev_x_q) - DW'(cur_x);
  assign dy_ab = DW'(prev_y_q) - DW'(cur_y);

  assign cr_a = dx_ba * py_a;   // cross product terms for the collinear test
  assign cr_b = dy_ba * px_a;
  assign lhs  = px_b * dy_ab;   // crossing test without the division
  assign rhs  = dx_ab * py_b;

  assign box_ok   = ((qx_q >= prev_x_q && qx_q <= cur_x) || (qx_q >= cur_x && qx_q <= prev_x_q))
                 && ((qy_q >= prev_y_q && qy_q <= cur_y) || (qy_q >= cur_y && qy_q <= prev_y_q));
  assign straddle = (cur_y > qy_q) != (prev_y_q > qy_q);
  assign dpos     = (prev_y_q > cur_y);

  assign ex_vld_d = rd_vld_q && !rd_first_q;

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
      if (rd_first_q) begin
        first_x_q <= rd_x_q;
        first_y_q <= rd_y_q;
      end
      cr_a_q     <= cr_a;
      cr_b_q     <= cr_b;
      lhs_q      <= lhs;
      rhs_q      <= rhs;
      box_q      <= box_ok;
      straddle_q <= straddle;
      dpos_q     <= dpos;
    end
  end

  // Edge stage 2: fold one edge into the verdict
  assign on_hit    = (cr_a_q == cr_b_q) && box_q;
  assign cross_hit = straddle_q && (dpos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q));

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      edge_acc_q <= 1'b0;
      par_acc_q  <= 1'b0;
    end else if (ex_vld_q) begin
      edge_acc_q <= edge_acc_q || on_hit;
      par_acc_q  <= par_acc_q ^ cross_hit;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      inside_q  <= out_inside;
      on_edge_q <= out_edge;
      status_q  <= out_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign on_edge_o    = on_edge_q;
  assign status_o     = status_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_rd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == S_RUN || state_q == S_WRAP))
    else $error("read stage valid without a walk step");

  a_ex_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_vld_q |-> $past(rd_vld_q && !rd_first_q))
    else $error("edge stage valid without a vertex pair");

  a_edge_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && on_edge_o) |-> inside_res_o)
    else $error("point on edge reported outside");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (!inside_res_o && !on_edge_o))
    else $error("flags set on a non-ok result");

endmodule
